FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSTB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSTB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cstb_pkg.sv
// ----------------------------------------------------------------------------
// cstb_pkg
// Types and constants of the software timer bank with expiry events.
// ----------------------------------------------------------------------------
`default_nettype none

package cstb_pkg;

	// Default number of timers in the bank.
	localparam int unsigned TIMER_COUNT_DEF = 8;

	// At most this many results are reported for one transaction.
	localparam int unsigned MAX_RESULTS = 8;
	localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// Operation codes on the input stream.
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	// Result kinds on the output stream.
	typedef enum logic [1:0] {
		KIND_TIMEOUT   = 2'd0,
		KIND_START_ACK = 2'd1,
		KIND_QUERY     = 2'd2
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START_TO,
		ST_START_ACK,
		ST_QUERY,
		ST_TICK_WB,
		ST_TICK_END
	} state_t;

	// One result item.
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  idx;
		logic [15:0] cookie;
		logic [15:0] remaining;
		logic        done;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/cookie_software_timer_bank_unit.sv
// Start, stop and query are accepted in the idle state; the first result is
// pushed from the following state once the output register is free, and the
// next transaction is taken once all results of the current one are handed to
// the output register. A tick walks the count memory one entry per cycle through
// its single read port, stalling while a new expiry meets a held one and a full
// output register. Reset clears the sequencer, the cookie counter and per-entry
// valid bits; an entry never written reads as zero, so no clearing pass is run.
// ----------------------------------------------------------------------------
// cookie_software_timer_bank_unit
// Bank of one-shot countdown timers with per-arming cookies. Counts and cookies
// live in two small synchronous memories that are read, modified and written
// back by a sequencer; results leave through a registered stream output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cookie_software_timer_bank_unit #(
	parameter int unsigned TIMER_COUNT = cstb_pkg::TIMER_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [2:0] timer_index, [18:3] period, rest zero
	input  wire logic [1:0]  s_tuser,   // [1:0] op
	// Output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [2:0] timer_index_res, [18:3] cookie,
	                                    // [34:19] remaining, [35] done_res, rest zero
	output logic [1:0]       m_tuser,   // [1:0] kind
	output logic             m_tlast    // last
);

	localparam int unsigned IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_COUNT - 1);
	localparam logic [cstb_pkg::RES_CNT_W-1:0] RES_MAX =
		cstb_pkg::RES_CNT_W'(cstb_pkg::MAX_RESULTS);

	// Input decode.
	cstb_pkg::op_t op_in;
	logic [2:0]    idx_in;
	logic [15:0]   period_in;
	logic          s_accept;
	logic          in_range;

	assign op_in     = cstb_pkg::op_t'(s_tuser);
	assign idx_in    = s_tdata[2:0];
	assign period_in = s_tdata[18:3];
	assign s_accept  = s_tvalid && s_tready;
	assign in_range  = (32'(idx_in) < TIMER_COUNT);

	// Memories and their valid bits.
	logic [15:0]            cnt_mem [TIMER_COUNT];
	logic [15:0]            ck_mem  [TIMER_COUNT];
	logic [TIMER_COUNT-1:0] cnt_vld_q;
	logic [TIMER_COUNT-1:0] ck_vld_q;
	logic [15:0]            cnt_rd_q;
	logic [15:0]            ck_rd_q;
	logic [IW-1:0]          rd_addr_q;

	// Control registers.
	cstb_pkg::state_t             state_q, state_d;
	logic [15:0]                  cookie_q;
	logic [15:0]                  start_ck_q;
	logic [IW-1:0]                start_idx_q;
	logic [cstb_pkg::RES_CNT_W-1:0] n_q;
	cstb_pkg::result_t            pend_q;
	logic                         pend_vld_q;
	cstb_pkg::result_t            out_q;
	logic                         out_vld_q;

	// Combinational controls.
	logic              out_free;
	logic              push;
	cstb_pkg::result_t push_res;
	logic              cnt_we, ck_we;
	logic [IW-1:0]     cnt_wa, ck_wa;
	logic [15:0]       cnt_wd, ck_wd;
	logic              rd_en;
	logic [IW-1:0]     rd_addr;
	logic              pend_load;
	cstb_pkg::result_t pend_new;
	logic              start_go;

	// Current entry as read, with never-written entries seen as zero.
	logic [15:0] cnt_cur, ck_cur, cnt_dec;
	logic        tick_hit;
	logic        tick_stall;

	assign cnt_cur    = cnt_vld_q[rd_addr_q] ? cnt_rd_q : 16'd0;
	assign ck_cur     = ck_vld_q[rd_addr_q] ? ck_rd_q : 16'd0;
	assign cnt_dec    = cnt_cur - 16'd1;
	assign tick_hit   = (cnt_cur == 16'd1) && (n_q < RES_MAX);
	assign out_free   = !out_vld_q || m_tready;
	assign tick_stall = tick_hit && pend_vld_q && !out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cstb_pkg::ST_IDLE: begin
				if (s_accept) begin
					if (op_in == cstb_pkg::OP_TICK) begin
						state_d = cstb_pkg::ST_TICK_WB;
					end else if (in_range && op_in == cstb_pkg::OP_START) begin
						state_d = (period_in == 16'd0) ? cstb_pkg::ST_START_TO
							: cstb_pkg::ST_START_ACK;
					end else if (in_range && op_in == cstb_pkg::OP_QUERY) begin
						state_d = cstb_pkg::ST_QUERY;
					end
				end
			end
			cstb_pkg::ST_START_TO: begin
				if (out_free) state_d = cstb_pkg::ST_START_ACK;
			end
			cstb_pkg::ST_START_ACK, cstb_pkg::ST_QUERY: begin
				if (out_free) state_d = cstb_pkg::ST_IDLE;
			end
			cstb_pkg::ST_TICK_WB: begin
				if (!tick_stall && rd_addr_q == LAST_IDX) state_d = cstb_pkg::ST_TICK_END;
			end
			cstb_pkg::ST_TICK_END: begin
				if (!pend_vld_q || out_free) state_d = cstb_pkg::ST_IDLE;
			end
			default: state_d = cstb_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: memory accesses, result pushes and holds.
	always_comb begin
		s_tready  = 1'b0;
		push      = 1'b0;
		push_res  = '0;
		cnt_we    = 1'b0;
		cnt_wa    = '0;
		cnt_wd    = '0;
		ck_we     = 1'b0;
		ck_wa     = '0;
		ck_wd     = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		pend_load = 1'b0;
		pend_new  = '0;
		start_go  = 1'b0;
		unique case (state_q)
			cstb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_accept) begin
					unique case (op_in)
						cstb_pkg::OP_START: begin
							if (in_range) begin
								start_go = 1'b1;
								ck_we    = 1'b1;
								ck_wa    = IW'(idx_in);
								ck_wd    = cookie_q + 16'd1;
								cnt_we   = 1'b1;
								cnt_wa   = IW'(idx_in);
								cnt_wd   = period_in;
							end
						end
						cstb_pkg::OP_STOP: begin
							if (in_range) begin
								cnt_we = 1'b1;
								cnt_wa = IW'(idx_in);
								cnt_wd = 16'd0;
							end
						end
						cstb_pkg::OP_TICK: begin
							rd_en   = 1'b1;
							rd_addr = '0;
						end
						cstb_pkg::OP_QUERY: begin
							if (in_range) begin
								rd_en   = 1'b1;
								rd_addr = IW'(idx_in);
							end
						end
						default: ;
					endcase
				end
			end
			cstb_pkg::ST_START_TO: begin
				push_res.kind   = cstb_pkg::KIND_TIMEOUT;
				push_res.idx    = 3'(start_idx_q);
				push_res.cookie = start_ck_q;
				push            = out_free;
			end
			cstb_pkg::ST_START_ACK: begin
				push_res.kind   = cstb_pkg::KIND_START_ACK;
				push_res.idx    = 3'(start_idx_q);
				push_res.cookie = start_ck_q;
				push_res.last   = 1'b1;
				push            = out_free;
			end
			cstb_pkg::ST_QUERY: begin
				push_res.kind      = cstb_pkg::KIND_QUERY;
				push_res.idx       = 3'(rd_addr_q);
				push_res.cookie    = ck_cur;
				push_res.remaining = cnt_cur;
				push_res.done      = (cnt_cur == 16'd0);
				push_res.last      = 1'b1;
				push               = out_free;
			end
			cstb_pkg::ST_TICK_WB: begin
				if (!tick_stall) begin
					cnt_we   = (cnt_cur != 16'd0);
					cnt_wa   = rd_addr_q;
					cnt_wd   = cnt_dec;
					// The next entry is read while this one is written back.
					if (rd_addr_q != LAST_IDX) begin
						rd_en   = 1'b1;
						rd_addr = rd_addr_q + IW'(1);
					end
					// A new expiry pushes out the held one, which is not the last.
					if (tick_hit) begin
						pend_load       = 1'b1;
						pend_new.kind   = cstb_pkg::KIND_TIMEOUT;
						pend_new.idx    = 3'(rd_addr_q);
						pend_new.cookie = ck_cur;
						push            = pend_vld_q;
						push_res        = pend_q;
					end
				end
			end
			cstb_pkg::ST_TICK_END: begin
				push_res      = pend_q;
				push_res.last = 1'b1;
				push          = pend_vld_q && out_free;
			end
			default: ;
		endcase
	end

	// Memory write ports.
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (ck_we) ck_mem[ck_wa] <= ck_wd;
	end

	// Memory read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			cnt_rd_q  <= cnt_mem[rd_addr];
			ck_rd_q   <= ck_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Valid bits: an entry reads as zero until first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			ck_vld_q  <= '0;
		end else begin
			if (cnt_we) cnt_vld_q[cnt_wa] <= 1'b1;
			if (ck_we) ck_vld_q[ck_wa] <= 1'b1;
		end
	end

	// Sequencer, cookie counter and tick bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cstb_pkg::ST_IDLE;
			cookie_q   <= 16'd0;
			n_q        <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_go) cookie_q <= cookie_q + 16'd1;
			if (s_accept) begin
				n_q        <= '0;
				pend_vld_q <= 1'b0;
			end else begin
				if (pend_load) begin
					pend_vld_q <= 1'b1;
					n_q        <= n_q + cstb_pkg::RES_CNT_W'(1);
				end else if (state_q == cstb_pkg::ST_TICK_END && push) begin
					pend_vld_q <= 1'b0;
				end
			end
		end
	end

	// Payload held for start results and the held tick result.
	always_ff @(posedge clk) begin
		if (start_go) begin
			start_ck_q  <= cookie_q + 16'd1;
			start_idx_q <= IW'(idx_in);
		end
		if (pend_load) pend_q <= pend_new;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (push) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) out_q <= push_res;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0, out_q.done, out_q.remaining, out_q.cookie, out_q.idx};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

	// Conditions used by the checks.
	logic in_tick;
	logic stop_acc;

	assign in_tick  = (state_q == cstb_pkg::ST_TICK_WB) || (state_q == cstb_pkg::ST_TICK_END);
	assign stop_acc = s_accept && (op_in == cstb_pkg::OP_STOP);

	// Checks on the sequencer.
	`CSTB_ASSERT_IMP(a_push_free, push, out_free, "result pushed into a full output register")
	`CSTB_ASSERT_IMP(a_res_cap, 1'b1, n_q <= RES_MAX, "tick reported more than the cap")
	`CSTB_ASSERT_IMP(a_pend_tick, pend_vld_q, in_tick, "held tick result outside a tick walk")
	`CSTB_ASSERT_NXT(a_stop_idle, stop_acc, state_q == cstb_pkg::ST_IDLE, "stop left it busy")
	`CSTB_ASSERT_NXT(a_cookie_adv, start_go, cookie_q == $past(cookie_q) + 16'd1, "no cookie step")

endmodule

`default_nettype wire

FILE: tb/sv/tb_cookie_software_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// tb_cookie_software_timer_bank_unit
// Self-checking bench for the timer bank. A table of directed operations runs
// first. Random operations follow under several idling patterns on both streams.
// A behavioral model of the bank predicts every timeout, start acknowledge and
// query reply, and a monitor checks each output transaction in order.
// ----------------------------------------------------------------------------
module tb_cookie_software_timer_bank_unit;

	import cstb_pkg::*;

	localparam int unsigned TIMERS = TIMER_COUNT_DEF;
	localparam int DRAIN_LIMIT = 20000;

	// One expected or observed result transaction.
	typedef struct packed {
		kind_t       kind;
		logic [2:0]  tmr;
		logic [15:0] cookie;
		logic [15:0] left;
		logic        done;
		logic        last;
	} timer_event_t;

	// One row of the directed table. Where typed is set, the expected result
	// is written out in the row (at most one), otherwise the model decides.
	typedef struct packed {
		op_t          op;
		logic [2:0]   tmr;
		logic [15:0]  period;
		logic         typed;
		logic         cnt;
		timer_event_t exp;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// Model state of the bank.
	logic [15:0] count_left [TIMERS];
	logic [15:0] armed_cookie [TIMERS];
	logic [15:0] cookie_src;

	timer_event_t step_events[$];
	timer_event_t pending_events[$];

	int errors = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	int tx_mode [4] = '{0, 75, 0, 25};
	int rx_mode [4] = '{0, 0, 75, 25};

	stim_row_t dir_rows [0:24] = '{
		// Fresh bank: every timer idle with cookie zero.
		'{OP_QUERY, 3'd0, 16'd0, 1'b1, 1'b1, '{KIND_QUERY, 3'd0, 16'd0, 16'd0, 1'b1, 1'b1}},
		'{OP_QUERY, 3'd7, 16'd0, 1'b1, 1'b1, '{KIND_QUERY, 3'd7, 16'd0, 16'd0, 1'b1, 1'b1}},
		'{OP_TICK, 3'd0, 16'd0, 1'b1, 1'b0, '0},
		// Stop of an idle timer has no effect and no result.
		'{OP_STOP, 3'd3, 16'd0, 1'b1, 1'b0, '0},
		// Longest period; first cookie handed out is one.
		'{OP_START, 3'd7, 16'hFFFF, 1'b1, 1'b1,
			'{KIND_START_ACK, 3'd7, 16'd1, 16'd0, 1'b0, 1'b1}},
		'{OP_QUERY, 3'd7, 16'd0, 1'b1, 1'b1,
			'{KIND_QUERY, 3'd7, 16'd1, 16'hFFFF, 1'b0, 1'b1}},
		// Zero period: immediate timeout, then the acknowledge.
		'{OP_START, 3'd0, 16'd0, 1'b0, 1'b0, '0},
		'{OP_QUERY, 3'd0, 16'd0, 1'b1, 1'b1, '{KIND_QUERY, 3'd0, 16'd2, 16'd0, 1'b1, 1'b1}},
		'{OP_START, 3'd1, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd2, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd3, 16'd2, 1'b0, 1'b0, '0},
		'{OP_TICK, 3'd5, 16'h5A5A, 1'b0, 1'b0, '0},
		'{OP_TICK, 3'd2, 16'hA5A5, 1'b0, 1'b0, '0},
		// Arm the whole bank so that a single tick expires every timer.
		'{OP_START, 3'd0, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd1, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd2, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd3, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd4, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd5, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd6, 16'd1, 1'b0, 1'b0, '0},
		'{OP_START, 3'd7, 16'd1, 1'b0, 1'b0, '0},
		'{OP_TICK, 3'd0, 16'd0, 1'b0, 1'b0, '0},
		// A stopped timer reports zero left but keeps its cookie.
		'{OP_START, 3'd4, 16'd5, 1'b0, 1'b0, '0},
		'{OP_STOP, 3'd4, 16'd0, 1'b0, 1'b0, '0},
		'{OP_QUERY, 3'd4, 16'd0, 1'b0, 1'b0, '0}
	};

	cookie_software_timer_bank_unit #(
		.TIMER_COUNT(TIMERS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [2:0] timer_index, [18:3] period, rest zero
		.s_tuser  (s_tuser),   // [1:0] op
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [2:0] timer_index_res, [18:3] cookie,
		                       // [34:19] remaining, [35] done_res, rest zero
		.m_tuser  (m_tuser),   // [1:0] kind
		.m_tlast  (m_tlast)    // last
	);

	always #1 clk = ~clk;

	// The receiver stalls at random with the current stall rate.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	function automatic string show_event(timer_event_t ev);
		return $sformatf("kind %0d timer %0d cookie %0d remaining %0d done %0d last %0d",
			ev.kind, ev.tmr, ev.cookie, ev.left, ev.done, ev.last);
	endfunction

	// Model of one operation: updates the bank and fills step_events.
	function automatic void predict_timer_op(op_t op, logic [2:0] tmr, logic [15:0] period);
		timer_event_t ev;
		int i;
		step_events.delete();
		case (op)
			OP_START: begin
				if (tmr < TIMERS) begin
					cookie_src = cookie_src + 16'd1;
					armed_cookie[tmr] = cookie_src;
					if (period == 16'd0) begin
						ev = '{KIND_TIMEOUT, tmr, cookie_src, 16'd0, 1'b0, 1'b0};
						step_events.push_back(ev);
					end
					count_left[tmr] = period;
					ev = '{KIND_START_ACK, tmr, cookie_src, 16'd0, 1'b0, 1'b0};
					step_events.push_back(ev);
				end
			end
			OP_STOP: begin
				if (tmr < TIMERS)
					count_left[tmr] = 16'd0;
			end
			OP_TICK: begin
				// Expiries are reported in index order, at most MAX_RESULTS of them.
				for (i = 0; i < TIMERS; i++) begin
					if (count_left[i] != 16'd0) begin
						count_left[i] = count_left[i] - 16'd1;
						if (count_left[i] == 16'd0 && step_events.size() < MAX_RESULTS) begin
							ev = '{KIND_TIMEOUT, 3'(i), armed_cookie[i], 16'd0, 1'b0, 1'b0};
							step_events.push_back(ev);
						end
					end
				end
			end
			default: begin
				if (tmr < TIMERS) begin
					ev = '{KIND_QUERY, tmr, armed_cookie[tmr], count_left[tmr],
						count_left[tmr] == 16'd0, 1'b0};
					step_events.push_back(ev);
				end
			end
		endcase
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
	endfunction

	// Offers one operation, waits for its transaction and records what it
	// should produce. Entered and left at a falling edge.
	task automatic send_item(input op_t op, input logic [2:0] tmr, input logic [15:0] period,
		input logic typed, input logic typed_cnt, input timer_event_t typed_ev);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {5'd0, period, tmr};
		do
			@(posedge clk);
		while (!s_tready);
		predict_timer_op(op, tmr, period);
		if (typed) begin
			if (typed_cnt)
				pending_events.push_back(typed_ev);
		end else begin
			foreach (step_events[k])
				pending_events.push_back(step_events[k]);
		end
		@(negedge clk);
	endtask

	task automatic send_random_item();
		int r;
		int p;
		op_t op;
		logic [15:0] period;
		r = $urandom_range(0, 99);
		if (r < 30)
			op = OP_START;
		else if (r < 45)
			op = OP_STOP;
		else if (r < 75)
			op = OP_TICK;
		else
			op = OP_QUERY;
		// Mostly short periods so that ticks expire timers often.
		p = $urandom_range(0, 9);
		if (p == 0)
			period = 16'd0;
		else if (p < 7)
			period = 16'($urandom_range(1, 6));
		else if (p < 9)
			period = 16'($urandom_range(7, 40));
		else
			period = 16'($urandom);
		send_item(op, 3'($urandom_range(0, 7)), period, 1'b0, 1'b0, '0);
	endtask

	// Stops offering, waits for every expected result, then lets the block settle.
	task automatic wait_until_drained();
		int waited;
		timer_event_t want;
		waited = 0;
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		while (pending_events.size() != 0) begin
			want = pending_events.pop_front();
			errors++;
			$display("%0t: missing result, expected %s, got nothing", $time,
				show_event(want));
		end
		repeat (TIMERS + 4) @(negedge clk);
	endtask

	// Checks each output transaction against the oldest expectation.
	always @(posedge clk) begin : check_results
		timer_event_t got;
		timer_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{kind_t'(m_tuser), m_tdata[2:0], m_tdata[18:3], m_tdata[34:19],
				m_tdata[35], m_tlast};
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected nothing, got %s", $time,
					show_event(got));
			end else begin
				want = pending_events.pop_front();
				if (got != want) begin
					errors++;
					$display("%0t: result mismatch, expected %s, got %s", $time,
						show_event(want), show_event(got));
				end
			end
		end
	end

	// Main sequence.
	initial begin
		int ph;
		int n;
		for (int i = 0; i < TIMERS; i++) begin
			count_left[i] = 16'd0;
			armed_cookie[i] = 16'd0;
		end
		cookie_src = 16'd0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table.
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].tmr, dir_rows[i].period,
				dir_rows[i].typed, dir_rows[i].cnt, dir_rows[i].exp);
		wait_until_drained();

		// Random operations under each idling pattern.
		for (ph = 0; ph < 4; ph++) begin
			tx_idle_pct = tx_mode[ph];
			rx_stall_pct = rx_mode[ph];
			for (n = 0; n < 26; n++) begin
				// Hold the sender until the bank has caught up once.
				if (ph == 1 && n == 13)
					wait_until_drained();
				send_random_item();
			end
			wait_until_drained();
		end

		if (errors == 0)
			$display("tb_cookie_software_timer_bank_unit OK");
		else
			$display("tb_cookie_software_timer_bank_unit NOT OK");
		$finish;
	end

	// Watchdog.
	initial begin
		#3000000;
		$display("tb_cookie_software_timer_bank_unit NOT OK");
		$finish;
	end

endmodule
